### design/slab_slot_allocator_core_macros.svh
// Assertion macros for the slab slot allocator.
// Used by the port-level checker; no other dependencies.
`ifndef SLAB_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slab allocator check failed");

// Next-cycle implication, disabled during reset.
`define SSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slab allocator check failed");

`endif

### design/ssa_pkg.sv
// Shared types, codes and a helper function of the slab slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ssa_pkg;

  localparam int DEF_POOL_SLABS = 16;
  localparam int DEF_MAX_SLOTS  = 64;

  localparam int MAP_W      = 64;
  localparam int SLOT_W     = 6;
  localparam int CNT_W      = 7;
  localparam int SLAB_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int REL_W      = 5;
  localparam int MODE_W     = 2;
  localparam int SPP_W      = 7;
  localparam int LIM_W      = 5;
  localparam int LIM_EFF_W  = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_PER_SLAB = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAB_LIMIT     = 1'd1;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SHRINK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SLAB  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [1:0] CL_UNUSED = 2'd0;
  localparam logic [1:0] CL_EMPTY  = 2'd1;
  localparam logic [1:0] CL_MIXED  = 2'd2;
  localparam logic [1:0] CL_FULL   = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_SHRINK = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              slab_ok;
    logic [SLAB_W-1:0] slab;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLAB_W-1:0]   got_slab;
    logic [SLOT_W-1:0]   got_slot;
    logic [REL_W-1:0]    released;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]     slots;
    logic [LIM_EFF_W-1:0] limit;
  } cfg_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } zsrch_t;

  function automatic zsrch_t first_zero(input logic [MAP_W-1:0] map,
                                        input logic [CNT_W-1:0] n);
    zsrch_t r;
    r = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!map[i] && (CNT_W'(i) < n)) begin
        r.found = 1'b1;
        r.idx   = SLOT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### design/slab_slot_allocator_core.sv
// Slab slot allocator. An alloc runs through dispatch/claim, take list head and bitmap scan
// before its result reaches the out_ ports; a rejected alloc, invalid free or unknown mode is
// answered at dispatch; a free walks its slab's list (not for a full slab), then relinks it;
// a shrink releases each empty slab in turn. One request in the back end at a time, so a new
// alloc waits for the last; the back end stalls while the two-entry result queue is full.
// Reset (synchronous, rst_n low) clears lists, classes, queues; slots_per_slab 63, slab_limit 16.
`timescale 1ns / 1ps
module slab_slot_allocator_core import ssa_pkg::*; #(
  parameter int POOL_SLABS = DEF_POOL_SLABS,
  parameter int MAX_SLOTS  = DEF_MAX_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [SLAB_W-1:0]     in_slab_id,
  input  logic [SLOT_W-1:0]     in_slot_id,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLAB_W-1:0]     out_got_slab,
  output logic [SLOT_W-1:0]     out_got_slot,
  output logic [REL_W-1:0]      out_released_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_CAP = (MAX_SLOTS < MAP_W) ? MAX_SLOTS : MAP_W;

  logic [SPP_W-1:0] spp_r, spp_nxt;
  logic [LIM_W-1:0] lim_r, lim_nxt;
  cfg_t             cfg;
  cmd_t             cmd;
  res_t             res;
  logic             cmd_vld, cmd_pop, res_room, res_push;

  always_comb begin
    spp_nxt = spp_r;
    lim_nxt = lim_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SLOTS_PER_SLAB: spp_nxt = cfg_wdata;
        REG_SLAB_LIMIT:     lim_nxt = cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r <= SPP_W'(63);
      lim_r <= LIM_W'(16);
    end else begin
      spp_r <= spp_nxt;
      lim_r <= lim_nxt;
    end
  end

  always_comb begin
    if (spp_r == '0) cfg.slots = CNT_W'(1);
    else if (CNT_W'(spp_r) > CNT_W'(SLOT_CAP)) cfg.slots = CNT_W'(SLOT_CAP);
    else cfg.slots = CNT_W'(spp_r);
    if (LIM_EFF_W'(lim_r) > LIM_EFF_W'(POOL_SLABS)) cfg.limit = LIM_EFF_W'(POOL_SLABS);
    else cfg.limit = LIM_EFF_W'(lim_r);
  end

  ssa_front #(.POOL_SLABS(POOL_SLABS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_mode    (in_mode),
    .in_slab_id (in_slab_id),
    .in_slot_id (in_slot_id),
    .cmd_vld    (cmd_vld),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd)
  );

  ssa_back #(.POOL_SLABS(POOL_SLABS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd_vld  (cmd_vld),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd),
    .res_room (res_room),
    .res_push (res_push),
    .res      (res)
  );

  ssa_resq u_resq (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_push           (res_push),
    .res                (res),
    .res_room           (res_room),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_status         (out_status),
    .out_got_slab       (out_got_slab),
    .out_got_slot       (out_got_slot),
    .out_released_count (out_released_count)
  );

endmodule

### design/ssa_front.sv
// Request front end: classifies incoming requests and queues them.
// Depends on ssa_pkg.
`timescale 1ns / 1ps
module ssa_front import ssa_pkg::*; #(
  parameter int POOL_SLABS = DEF_POOL_SLABS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [SLAB_W-1:0] in_slab_id,
  input  logic [SLOT_W-1:0] in_slot_id,
  output logic              cmd_vld,
  input  logic              cmd_pop,
  output cmd_t              cmd
);

  cmd_t       q_r [2];
  cmd_t       cls_cmd;
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  always_comb begin
    cls_cmd.slab    = in_slab_id;
    cls_cmd.slot    = in_slot_id;
    cls_cmd.slab_ok = (LIM_EFF_W'(in_slab_id) < LIM_EFF_W'(POOL_SLABS));
    case (in_mode)
      MODE_ALLOC:  cls_cmd.op = OP_ALLOC;
      MODE_FREE:   cls_cmd.op = OP_FREE;
      MODE_SHRINK: cls_cmd.op = OP_SHRINK;
      default:     cls_cmd.op = OP_NOP;
    endcase
  end

  assign in_full = (cnt_r == 2'd2);
  assign cmd_vld = (cnt_r != 2'd0);
  assign cmd     = q_r[rp_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = cmd_pop && cmd_vld;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= cls_cmd;
    end
  end

endmodule

### design/ssa_back.sv
// Allocation engine: slab bitmaps, free counts, class and list state,
// and the sequencer that runs alloc, free and shrink. Depends on ssa_pkg.
`timescale 1ns / 1ps
module ssa_back import ssa_pkg::*; #(
  parameter int POOL_SLABS = DEF_POOL_SLABS
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic cmd_vld,
  output logic cmd_pop,
  input  cmd_t cmd,
  input  logic res_room,
  output logic res_push,
  output res_t res
);

  localparam int IW = (POOL_SLABS > 1) ? $clog2(POOL_SLABS) : 1;
  localparam int LW = IW + 1;
  localparam int CW = $clog2(POOL_SLABS + 1);
  localparam logic [LW-1:0] NIL = {1'b1, {IW{1'b0}}};

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_TAKE    = 6'b000010,
    S_SCAN    = 6'b000100,
    S_FWALK   = 6'b001000,
    S_FRELINK = 6'b010000,
    S_SHRINK  = 6'b100000
  } state_t;

  state_t            st_r, st_nxt;
  logic [MAP_W-1:0]  map_r  [POOL_SLABS];
  logic [MAP_W-1:0]  map_nxt[POOL_SLABS];
  logic [CNT_W-1:0]  free_r  [POOL_SLABS];
  logic [CNT_W-1:0]  free_nxt[POOL_SLABS];
  logic [1:0]        cls_r  [POOL_SLABS];
  logic [1:0]        cls_nxt[POOL_SLABS];
  logic [LW-1:0]     link_r  [POOL_SLABS];
  logic [LW-1:0]     link_nxt[POOL_SLABS];
  logic [LW-1:0]     empty_hd_r, empty_hd_nxt;
  logic [LW-1:0]     mixed_hd_r, mixed_hd_nxt;
  logic [LW-1:0]     cur_r, cur_nxt;
  logic [LW-1:0]     prev_r, prev_nxt;
  logic [IW-1:0]     s_r, s_nxt;
  logic              walk_mixed_r, walk_mixed_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pick_found;
  logic [IW-1:0]     pick_idx;

  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int i = POOL_SLABS - 1; i >= 0; i--) begin
      if (cls_r[i] == CL_UNUSED && LIM_EFF_W'(i) < cfg.limit) begin
        pick_found = 1'b1;
        pick_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    logic [IW-1:0]    sel;
    logic [IW-1:0]    fs;
    logic [IW-1:0]    cidx;
    logic [CNT_W-1:0] f;
    zsrch_t           z;
    sel  = '0;
    fs   = IW'(cmd.slab);
    cidx = cur_r[IW-1:0];
    f    = '0;
    z    = first_zero(map_r[s_r], cfg.slots);

    st_nxt         = st_r;
    map_nxt        = map_r;
    free_nxt       = free_r;
    cls_nxt        = cls_r;
    link_nxt       = link_r;
    empty_hd_nxt   = empty_hd_r;
    mixed_hd_nxt   = mixed_hd_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    s_nxt          = s_r;
    walk_mixed_nxt = walk_mixed_r;
    cnt_nxt        = cnt_r;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    res            = '0;

    case (st_r)
      S_IDLE: begin
        if (cmd_vld && res_room) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_ALLOC: begin
              if (mixed_hd_r[IW] && empty_hd_r[IW]) begin
                if (!pick_found) begin
                  res_push   = 1'b1;
                  res.status = ST_NO_SLAB;
                end else begin
                  map_nxt[pick_idx]  = '0;
                  free_nxt[pick_idx] = cfg.slots;
                  cls_nxt[pick_idx]  = CL_EMPTY;
                  link_nxt[pick_idx] = NIL;
                  empty_hd_nxt       = {1'b0, pick_idx};
                  st_nxt             = S_TAKE;
                end
              end else begin
                st_nxt = S_TAKE;
              end
            end
            OP_FREE: begin
              if (!cmd.slab_ok || cls_r[fs] == CL_UNUSED || !map_r[fs][cmd.slot]) begin
                res_push   = 1'b1;
                res.status = ST_BAD_FREE;
              end else begin
                map_nxt[fs][cmd.slot] = 1'b0;
                s_nxt    = fs;
                prev_nxt = NIL;
                if (cls_r[fs] == CL_EMPTY) begin
                  cur_nxt        = empty_hd_r;
                  walk_mixed_nxt = 1'b0;
                  st_nxt         = S_FWALK;
                end else if (cls_r[fs] == CL_MIXED) begin
                  cur_nxt        = mixed_hd_r;
                  walk_mixed_nxt = 1'b1;
                  st_nxt         = S_FWALK;
                end else begin
                  st_nxt = S_FRELINK;
                end
              end
            end
            OP_SHRINK: begin
              cur_nxt = empty_hd_r;
              cnt_nxt = '0;
              st_nxt  = S_SHRINK;
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      S_TAKE: begin
        if (!mixed_hd_r[IW]) begin
          sel          = mixed_hd_r[IW-1:0];
          mixed_hd_nxt = link_r[sel];
        end else begin
          sel          = empty_hd_r[IW-1:0];
          empty_hd_nxt = link_r[sel];
        end
        link_nxt[sel] = NIL;
        s_nxt         = sel;
        st_nxt        = S_SCAN;
      end
      S_SCAN: begin
        res_push = 1'b1;
        st_nxt   = S_IDLE;
        if (!z.found) begin
          free_nxt[s_r] = '0;
          cls_nxt[s_r]  = CL_FULL;
          res.status    = ST_NO_SLAB;
        end else begin
          map_nxt[s_r][z.idx] = 1'b1;
          f = free_r[s_r];
          if (f > cfg.slots) f = cfg.slots;
          if (f != '0) f = f - 1'b1;
          free_nxt[s_r] = f;
          if (f == '0) begin
            cls_nxt[s_r] = CL_FULL;
          end else begin
            cls_nxt[s_r]  = CL_MIXED;
            link_nxt[s_r] = mixed_hd_r;
            mixed_hd_nxt  = {1'b0, s_r};
          end
          res.status   = ST_OK;
          res.got_slab = SLAB_W'(s_r);
          res.got_slot = z.idx;
        end
      end
      S_FWALK: begin
        if (cur_r[IW]) begin
          st_nxt = S_FRELINK;
        end else if (cidx == s_r) begin
          if (prev_r[IW]) begin
            if (walk_mixed_r) mixed_hd_nxt = link_r[cidx];
            else empty_hd_nxt = link_r[cidx];
          end else begin
            link_nxt[prev_r[IW-1:0]] = link_r[cidx];
          end
          link_nxt[cidx] = NIL;
          st_nxt         = S_FRELINK;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_r[cidx];
        end
      end
      S_FRELINK: begin
        f = free_r[s_r];
        if (f < cfg.slots) f = f + 1'b1;
        if (f > cfg.slots) f = cfg.slots;
        free_nxt[s_r] = f;
        if (f == cfg.slots) begin
          cls_nxt[s_r]  = CL_EMPTY;
          link_nxt[s_r] = empty_hd_r;
          empty_hd_nxt  = {1'b0, s_r};
        end else begin
          cls_nxt[s_r]  = CL_MIXED;
          link_nxt[s_r] = mixed_hd_r;
          mixed_hd_nxt  = {1'b0, s_r};
        end
        res_push = 1'b1;
        st_nxt   = S_IDLE;
      end
      S_SHRINK: begin
        if (cur_r[IW]) begin
          empty_hd_nxt = NIL;
          res_push     = 1'b1;
          res.released = REL_W'(cnt_r);
          st_nxt       = S_IDLE;
        end else begin
          cls_nxt[cidx]  = CL_UNUSED;
          link_nxt[cidx] = NIL;
          cnt_nxt        = CW'(cnt_r + 1'b1);
          cur_nxt        = link_r[cidx];
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      empty_hd_r <= NIL;
      mixed_hd_r <= NIL;
      for (int i = 0; i < POOL_SLABS; i++) begin
        cls_r[i]  <= CL_UNUSED;
        link_r[i] <= NIL;
      end
    end else begin
      st_r       <= st_nxt;
      empty_hd_r <= empty_hd_nxt;
      mixed_hd_r <= mixed_hd_nxt;
      cls_r      <= cls_nxt;
      link_r     <= link_nxt;
    end
  end

  always_ff @(posedge clk) begin
    map_r        <= map_nxt;
    free_r       <= free_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    s_r          <= s_nxt;
    walk_mixed_r <= walk_mixed_nxt;
    cnt_r        <= cnt_nxt;
  end

endmodule

### design/ssa_resq.sv
// Result queue: holds finished results until the consumer pops them.
// Depends on ssa_pkg.
`timescale 1ns / 1ps
module ssa_resq import ssa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  res_t                res,
  output logic                res_room,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLAB_W-1:0]   out_got_slab,
  output logic [SLOT_W-1:0]   out_got_slot,
  output logic [REL_W-1:0]    out_released_count
);

  res_t       q_r [2];
  res_t       head;
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign res_room  = (cnt_r != 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign do_pop    = out_pop && !out_empty;
  assign head      = q_r[rp_r];

  assign out_status         = head.status;
  assign out_got_slab       = head.got_slab;
  assign out_got_slot       = head.got_slot;
  assign out_released_count = head.released;

  always_comb begin
    wp_nxt  = res_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, res_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wp_r] <= res;
    end
  end

endmodule

### design/ssa_checker.sv
// Port-level checker for the slab slot allocator, bound to the top level.
// Depends on ssa_pkg and slab_slot_allocator_core_macros.svh.
`timescale 1ns / 1ps
`include "slab_slot_allocator_core_macros.svh"
module ssa_checker import ssa_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_empty,
  input logic                  out_pop,
  input logic [STATUS_W-1:0]   out_status,
  input logic [SLAB_W-1:0]     out_got_slab,
  input logic [SLOT_W-1:0]     out_got_slot,
  input logic [REL_W-1:0]      out_released_count
);

  `SSA_ASSERT_NXT(a_head_holds, !out_empty && !out_pop, $stable(out_status) && $stable(out_got_slab) && $stable(out_got_slot) && $stable(out_released_count))
  `SSA_ASSERT_IMP(a_status_legal, !out_empty, out_status == ST_OK || out_status == ST_NO_SLAB || out_status == ST_BAD_FREE)
  `SSA_ASSERT_IMP(a_error_clean, !out_empty && out_status != ST_OK, out_got_slab == '0 && out_got_slot == '0 && out_released_count == '0)
  `SSA_ASSERT_IMP(a_shrink_clean, !out_empty && out_released_count != '0, out_status == ST_OK && out_got_slab == '0 && out_got_slot == '0)

endmodule

bind slab_slot_allocator_core ssa_checker u_ssa_checker (.*);
